>>> hw/rtl/vaa_pkg.sv
// shared constants, types and command/status structures of the autocorrelation accumulator
package vaa_pkg;
    localparam int MAX_LAG       = 64;
    localparam int NUM_PARTICLES = 1024;
    localparam int NUM_SPECIES   = 8;

    localparam int LAG_W   = $clog2(MAX_LAG);
    localparam int CNT_W   = LAG_W + 1;
    localparam int PART_W  = 10;
    localparam int SPEC_W  = 3;
    localparam int VEL_W   = 24;
    localparam int CFG_W   = 7;
    localparam int SUM_W   = 64;
    localparam int TICK_W  = 32;
    localparam int PROD_W  = 2 * VEL_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int HIST_W  = 3 * VEL_W;
    localparam int HIST_AW = PART_W + LAG_W;
    localparam int ACC_AW  = SPEC_W + LAG_W;
    localparam int ACC_DEPTH = 1 << ACC_AW;
    localparam logic [CFG_W-1:0] CORR_RESET = 7'd50;

    typedef struct packed {
        logic              clear;
        logic [ACC_AW-1:0] clr_addr;
        logic              capture;
        logic              hist_wr;
        logic              issue;
        logic [LAG_W-1:0]  issue_k;
        logic              rd_issue;
        logic              out_load;
        logic              tick_adv;
    } vaa_cmd_t;

    typedef struct packed {
        logic             sample_ok;
        logic             acc_ok;
        logic             last;
        logic [CNT_W-1:0] n_lags;
        logic             pipe_busy;
        logic             out_free;
    } vaa_sts_t;
endpackage

>>> hw/rtl/vaa_if.sv
// request and result channel interfaces
interface vaa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [vaa_pkg::PART_W-1:0]    particle_index;
    logic [vaa_pkg::SPEC_W-1:0]    species_index;
    logic signed [vaa_pkg::VEL_W-1:0] vel_x;
    logic signed [vaa_pkg::VEL_W-1:0] vel_y;
    logic signed [vaa_pkg::VEL_W-1:0] vel_z;
    logic [vaa_pkg::LAG_W-1:0]     lag;
    logic                          last_in_tick;
    modport source (output valid, kind, particle_index, species_index, vel_x, vel_y, vel_z,
                    lag, last_in_tick, input ready);
    modport sink (input valid, kind, particle_index, species_index, vel_x, vel_y, vel_z,
                  lag, last_in_tick, output ready);
endinterface

interface vaa_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vaa_pkg::SUM_W-1:0]  bin_sum;
    logic [vaa_pkg::TICK_W-1:0]        ticks_done;
    logic                              lag_valid;
    modport source (output valid, bin_sum, ticks_done, lag_valid, input ready);
    modport sink (input valid, bin_sum, ticks_done, lag_valid, output ready);
endinterface

>>> hw/rtl/velocity_autocorrelation_accumulator_unit.sv
// top level of the velocity autocorrelation accumulator
// After reset the accumulator memory is cleared, one bin per cycle, during which no request
// is taken (configuration writes still land). A sample request walks n = min(filled lags + 1,
// corr_length) lags, with a corr_length of zero taken as 1 and one above 64 taken as 64:
// the velocity is stored first, then one lag per cycle is issued to the single read port of
// the history and accumulator memories and drains through a multiply, add and saturating
// accumulate pipeline. A read request waits until the result register is free; samples are
// taken while a read result still waits. One request is worked on at a time.
module velocity_autocorrelation_accumulator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [vaa_pkg::CFG_W-1:0] cfg_wdata,
    vaa_in_if.sink                    in_req,
    vaa_out_if.source                 out_res
);
    vaa_pkg::vaa_cmd_t cmd;
    vaa_pkg::vaa_sts_t sts;

    vaa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_req.valid),
        .in_kind  (in_req.kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    vaa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_req    (in_req),
        .out_res   (out_res)
    );
endmodule

>>> hw/rtl/vaa_datapath.sv
// history and accumulator memories, dot product pipeline and tick state
module vaa_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vaa_pkg::vaa_cmd_t           cmd,
    output vaa_pkg::vaa_sts_t           sts,
    input  logic                        cfg_we,
    input  logic [vaa_pkg::CFG_W-1:0]   cfg_wdata,
    vaa_in_if.sink                      in_req,
    vaa_out_if.source                   out_res
);
    logic [vaa_pkg::HIST_W-1:0] hist_mem [1 << vaa_pkg::HIST_AW];
    logic [vaa_pkg::SUM_W-1:0]  acc_mem  [vaa_pkg::ACC_DEPTH];

    logic [vaa_pkg::CFG_W-1:0]  corr_reg;
    logic [vaa_pkg::LAG_W-1:0]  head_reg;
    logic [vaa_pkg::CNT_W-1:0]  filled_reg;
    logic [vaa_pkg::TICK_W-1:0] tick_reg;

    logic                       kind_reg;
    logic [vaa_pkg::PART_W-1:0] part_reg;
    logic [vaa_pkg::SPEC_W-1:0] spec_reg;
    logic signed [vaa_pkg::VEL_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [vaa_pkg::LAG_W-1:0]  lag_reg;
    logic                       last_reg;

    logic [vaa_pkg::HIST_W-1:0] hist_q_reg;
    logic [vaa_pkg::SUM_W-1:0]  acc_q_reg;
    logic                       v1_reg, v2_reg, v3_reg;
    logic [vaa_pkg::ACC_AW-1:0] a1_reg, a2_reg, a3_reg;
    logic [vaa_pkg::SUM_W-1:0]  acc2_reg, acc3_reg;
    logic signed [vaa_pkg::PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [vaa_pkg::DOT_W-1:0]  dot_reg;

    logic                       out_valid_reg;
    logic signed [vaa_pkg::SUM_W-1:0] out_sum_reg;
    logic [vaa_pkg::TICK_W-1:0] out_tick_reg;
    logic                       out_lv_reg;

    logic [vaa_pkg::CNT_W:0]    fill_inc;
    logic [vaa_pkg::CNT_W:0]    len;
    logic [vaa_pkg::CNT_W:0]    n_full;
    logic [vaa_pkg::ACC_AW-1:0] acc_raddr;
    logic [vaa_pkg::HIST_AW-1:0] hist_raddr;
    logic [vaa_pkg::SUM_W:0]    sum_wide;
    logic [vaa_pkg::SUM_W-1:0]  sum_sat;

    // lag count for this sample
    always_comb
    begin
        fill_inc = {1'b0, filled_reg} + 1'b1;
        if (corr_reg == '0)
            len = (vaa_pkg::CNT_W+1)'(1);
        else if ({1'b0, corr_reg} > (vaa_pkg::CFG_W+1)'(vaa_pkg::MAX_LAG))
            len = (vaa_pkg::CNT_W+1)'(vaa_pkg::MAX_LAG);
        else
            len = (vaa_pkg::CNT_W+1)'(corr_reg);
        n_full = (fill_inc < len) ? fill_inc : len;
    end

    assign sts.sample_ok = 32'(part_reg) < vaa_pkg::NUM_PARTICLES;
    assign sts.acc_ok    = 32'(spec_reg) < vaa_pkg::NUM_SPECIES;
    assign sts.last      = last_reg && !kind_reg;
    assign sts.n_lags    = n_full[vaa_pkg::CNT_W-1:0];
    assign sts.pipe_busy = v1_reg | v2_reg | v3_reg;
    assign sts.out_free  = !out_valid_reg || out_res.ready;

    assign in_req.ready = cmd.capture;

    // configuration and tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg   <= vaa_pkg::CORR_RESET;
            head_reg   <= '0;
            filled_reg <= '0;
            tick_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                corr_reg <= cfg_wdata;
            if (cmd.tick_adv)
            begin
                head_reg <= head_reg + 1'b1;
                tick_reg <= tick_reg + 1'b1;
                if (filled_reg < vaa_pkg::CNT_W'(vaa_pkg::MAX_LAG))
                    filled_reg <= filled_reg + 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_req.valid)
        begin
            kind_reg <= in_req.kind;
            part_reg <= in_req.particle_index;
            spec_reg <= in_req.species_index;
            vx_reg   <= in_req.vel_x;
            vy_reg   <= in_req.vel_y;
            vz_reg   <= in_req.vel_z;
            lag_reg  <= in_req.lag;
            last_reg <= in_req.last_in_tick;
        end
    end

    // history memory
    assign hist_raddr = {part_reg, head_reg - cmd.issue_k};

    always_ff @(posedge clk)
    begin
        if (cmd.hist_wr)
            hist_mem[{part_reg, head_reg}] <= {vx_reg, vy_reg, vz_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            hist_q_reg <= hist_mem[hist_raddr];
    end

    // accumulator memory
    assign acc_raddr = cmd.rd_issue ? {spec_reg, lag_reg} : {spec_reg, cmd.issue_k};

    always_ff @(posedge clk)
    begin
        if (cmd.issue || cmd.rd_issue)
            acc_q_reg <= acc_mem[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            acc_mem[cmd.clr_addr] <= '0;
        else if (v3_reg)
            acc_mem[a3_reg] <= sum_sat;
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // products, dot sum
    always_ff @(posedge clk)
    begin
        a1_reg   <= {spec_reg, cmd.issue_k};
        px_reg   <= vx_reg * $signed(hist_q_reg[3*vaa_pkg::VEL_W-1:2*vaa_pkg::VEL_W]);
        py_reg   <= vy_reg * $signed(hist_q_reg[2*vaa_pkg::VEL_W-1:vaa_pkg::VEL_W]);
        pz_reg   <= vz_reg * $signed(hist_q_reg[vaa_pkg::VEL_W-1:0]);
        acc2_reg <= acc_q_reg;
        a2_reg   <= a1_reg;
        dot_reg  <= vaa_pkg::DOT_W'(px_reg) + vaa_pkg::DOT_W'(py_reg)
                  + vaa_pkg::DOT_W'(pz_reg);
        acc3_reg <= acc2_reg;
        a3_reg   <= a2_reg;
    end

    // saturating accumulate
    always_comb
    begin
        sum_wide = {acc3_reg[vaa_pkg::SUM_W-1], acc3_reg}
                 + {{(vaa_pkg::SUM_W+1-vaa_pkg::DOT_W){dot_reg[vaa_pkg::DOT_W-1]}}, dot_reg};
        if (sum_wide[vaa_pkg::SUM_W] != sum_wide[vaa_pkg::SUM_W-1])
            sum_sat = sum_wide[vaa_pkg::SUM_W] ? {1'b1, {(vaa_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(vaa_pkg::SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[vaa_pkg::SUM_W-1:0];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sum_reg  <= $signed(acc_q_reg);
            out_tick_reg <= tick_reg;
            out_lv_reg   <= {1'b0, lag_reg} < filled_reg;
        end
    end

    assign out_res.valid      = out_valid_reg;
    assign out_res.bin_sum    = out_sum_reg;
    assign out_res.ticks_done = out_tick_reg;
    assign out_res.lag_valid  = out_lv_reg;
endmodule

>>> hw/rtl/vaa_ctrl.sv
// controller state machine: clearing pass, request decode and lag sequencing
module vaa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    input  vaa_pkg::vaa_sts_t sts,
    output vaa_pkg::vaa_cmd_t cmd
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_RWAIT = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [vaa_pkg::ACC_AW-1:0] clr_reg, clr_next;
    logic [vaa_pkg::LAG_W-1:0]  k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.clr_addr = clr_reg;
        cmd.issue_k  = k_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == vaa_pkg::ACC_AW'(vaa_pkg::ACC_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.capture = 1'b1;
                if (in_valid)
                    state_next = in_kind ? ST_READ : ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.hist_wr = sts.sample_ok;
                k_next      = '0;
                state_next  = (sts.sample_ok && sts.acc_ok) ? ST_RUN : ST_DRAIN;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                k_next    = k_reg + 1'b1;
                if ({1'b0, k_reg} == sts.n_lags - 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.tick_adv = sts.last;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !cmd.issue && !cmd.rd_issue && !cmd.capture)
        else $error("clearing pass overlaps other work");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_adv |-> !sts.pipe_busy)
        else $error("tick advanced with lags in flight");
    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> state_reg == ST_RWAIT)
        else $error("read issue not followed by result wait");
endmodule
